@@ rtl/fwpq_pkg.sv @@
// package for the weight prune / quantize stream
// types and constants shared by the front, back and top level; no dependencies
package fwpq_pkg;

   localparam logic [1:0] MODE_PRUNE    = 2'd0;
   localparam logic [1:0] MODE_QUANTIZE = 2'd1;
   localparam logic [1:0] MODE_PASS     = 2'd2;

   localparam logic       CSR_MODE      = 1'b0;
   localparam logic       CSR_THRESHOLD = 1'b1;

   localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
   localparam logic [31:0] MAG_MASK  = 32'h7FFF_FFFF;
   localparam logic [31:0] EXP_ALL   = 32'h7F80_0000;
   localparam logic [31:0] SAT_MAX   = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] weight_bits;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [31:0] value_bits;
      logic        value_valid;
      logic        end_of_stream;
      logic [31:0] total_read;
      logic [31:0] total_written;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [31:0] weight_bits;
      logic        keep;
      logic        quant;
      logic        last;
   } work_type;

endpackage

@@ rtl/fwpq_front.sv @@
// front part: accepts weights, decides keep / quantize per mode
// depends on fwpq_pkg
module fwpq_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  fwpq_pkg::req_type  req_data,
   input  logic [1:0]         mode,
   input  logic [31:0]        threshold,
   output logic               work_valid,
   input  logic               work_ready,
   output fwpq_pkg::work_type work_data
);
   logic               valid_ff, valid_in;
   fwpq_pkg::work_type data_ff, data_in;
   logic               take;
   logic               w_nan, t_nan, at_least;

   assign full = valid_ff && !work_ready;
   assign take = push && !full;

   always_comb begin
      w_nan    = (req_data.weight_bits & fwpq_pkg::MAG_MASK) > fwpq_pkg::EXP_ALL;
      t_nan    = (threshold & fwpq_pkg::MAG_MASK) > fwpq_pkg::EXP_ALL;
      at_least = !w_nan && !t_nan &&
                 (threshold[31] || ((req_data.weight_bits & fwpq_pkg::MAG_MASK) >= threshold));
      data_in.weight_bits = req_data.weight_bits;
      data_in.last        = req_data.last;
      data_in.quant       = (mode == fwpq_pkg::MODE_QUANTIZE);
      data_in.keep        = (mode == fwpq_pkg::MODE_PRUNE) ? at_least : 1'b1;
      valid_in            = take || (valid_ff && !work_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign work_valid = valid_ff;
   assign work_data  = data_ff;
endmodule

@@ rtl/fwpq_queue.sv @@
// short queue between front and back
// depends on fwpq_pkg
module fwpq_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  fwpq_pkg::work_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output fwpq_pkg::work_type out_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   fwpq_pkg::work_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          wr, rd;

   assign in_ready  = cnt_ff != DEPTH[AW:0];
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   always_comb begin
      wr_in  = wr ? ((wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = rd ? ((rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + {{AW{1'b0}}, wr} - {{AW{1'b0}}, rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (wr) begin
         mem_ff[wr_ff] <= in_data;
      end
   end
endmodule

@@ rtl/fwpq_back.sv @@
// back part: quantizes, counts, builds results into an output register
// depends on fwpq_pkg
module fwpq_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               work_valid,
   output logic               work_ready,
   input  fwpq_pkg::work_type work_data,
   output logic               empty,
   input  logic               pop,
   output fwpq_pkg::rsp_type  rsp_data
);
   logic              out_ff, out_in;
   fwpq_pkg::rsp_type rsp_ff, rsp_in;
   logic [31:0]       rcnt_ff, rcnt_in, wcnt_ff, wcnt_in, rsat, wsat;
   logic [31:0]       qval;
   logic              take, emit;
   logic [7:0]        e;
   logic [4:0]        k;
   logic [24:0]       r;
   logic [4:0]        p;
   logic [23:0]       sig;
   logic [47:0]       sum;

   assign work_ready = !out_ff || pop;
   assign take       = work_valid && work_ready;
   assign emit       = work_data.keep || work_data.last;

   always_comb begin
      e   = work_data.weight_bits[30:23];
      sig = {1'b1, work_data.weight_bits[22:0]};
      k   = 5'(8'd146 - e);
      sum = {24'd0, sig} + (48'd1 << (k - 5'd1));
      r   = 25'(sum >> k);
      p   = 5'd0;
      for (int i = 1; i < 25; i++) begin
         if (r[i]) begin
            p = 5'(i);
         end
      end
      if (e == 8'hFF) begin
         qval = work_data.weight_bits;
      end else if (e >= 8'd251) begin
         qval = (work_data.weight_bits & fwpq_pkg::SIGN_MASK) | fwpq_pkg::EXP_ALL;
      end else if (e >= 8'd146) begin
         qval = work_data.weight_bits;
      end else if (e < 8'd122 || r == '0) begin
         qval = work_data.weight_bits & fwpq_pkg::SIGN_MASK;
      end else begin
         qval = {work_data.weight_bits[31], 8'(p + 8'd123), 23'((r << (5'd23 - p)))};
      end

      rsat = (rcnt_ff != fwpq_pkg::SAT_MAX) ? rcnt_ff + 32'd1 : rcnt_ff;
      wsat = (work_data.keep && wcnt_ff != fwpq_pkg::SAT_MAX) ? wcnt_ff + 32'd1 : wcnt_ff;
      rcnt_in = rcnt_ff;
      wcnt_in = wcnt_ff;
      if (take) begin
         rcnt_in = work_data.last ? '0 : rsat;
         wcnt_in = work_data.last ? '0 : wsat;
      end

      rsp_in.value_bits    = !work_data.keep ? '0 : (work_data.quant ? qval : work_data.weight_bits);
      rsp_in.value_valid   = work_data.keep;
      rsp_in.end_of_stream = work_data.last;
      rsp_in.total_read    = work_data.last ? rsat : '0;
      rsp_in.total_written = work_data.last ? wsat : '0;

      out_in = (take && emit) || (out_ff && !pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff  <= 1'b0;
         rcnt_ff <= '0;
         wcnt_ff <= '0;
      end else begin
         out_ff  <= out_in;
         rcnt_ff <= rcnt_in;
         wcnt_ff <= wcnt_in;
      end
      if (take && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign empty    = !out_ff;
   assign rsp_data = rsp_ff;
endmodule

@@ rtl/float_weight_prune_quantize_stream.sv @@
// top level of the weight prune / quantize stream
// depends on fwpq_pkg, fwpq_front, fwpq_queue, fwpq_back
//
//  channel  handshake        payload
//  req      push / full      req_data (weight_bits, last)
//  rsp      empty / pop      rsp_data (value, flags, totals)
//  csr      csr_we           csr_index, csr_wdata
//
// one weight per cycle sustained while pop keeps up; a weight passes the front register,
// the queue and the output register before empty goes low
// synchronous active-high reset clears control, counters and valid flags, not the data registers
// a stalled pop backs up through the queue and then raises full
module float_weight_prune_quantize_stream #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  fwpq_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output fwpq_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);
   logic [1:0]  mode_ff;
   logic [31:0] thr_ff;
   logic               f_valid, f_ready, b_valid, b_ready;
   fwpq_pkg::work_type f_data, b_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= fwpq_pkg::MODE_PASS;
         thr_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            fwpq_pkg::CSR_MODE:      mode_ff <= csr_wdata[1:0];
            fwpq_pkg::CSR_THRESHOLD: thr_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   fwpq_front u_front (
      .clock, .reset, .push, .full, .req_data,
      .mode(mode_ff), .threshold(thr_ff),
      .work_valid(f_valid), .work_ready(f_ready), .work_data(f_data)
   );

   fwpq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   fwpq_back u_back (
      .clock, .reset,
      .work_valid(b_valid), .work_ready(b_ready), .work_data(b_data),
      .empty, .pop, .rsp_data
   );

   // non-final results carry no totals
   a_totals_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.end_of_stream) |-> (rsp_data.total_read == '0 &&
                                               rsp_data.total_written == '0))
      else $error("totals on non-final transfer");

   // a shown result is either kept or closes the stream
   a_result_reason: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.value_valid || rsp_data.end_of_stream))
      else $error("empty result transfer");

   // result holds while not popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("result changed under stall");
endmodule

@@ tb/sv/tb.sv @@
// testbench for float_weight_prune_quantize_stream
// depends on fwpq_pkg and the rtl top level; predicts prune / quantize / pass results
module tb;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   fwpq_pkg::req_type     req_data = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   fwpq_pkg::rsp_type     rsp_data;
   logic                  csr_we = 1'b0;
   logic                  csr_index = fwpq_pkg::CSR_MODE;
   logic [31:0]           csr_wdata = '0;

   float_weight_prune_quantize_stream DUT (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   fwpq_pkg::req_type weight_q[$];
   fwpq_pkg::rsp_type filtered_q[$];
   logic [1:0]  cur_mode = fwpq_pkg::MODE_PASS;
   logic [31:0] cur_threshold = '0;
   logic [31:0] seen_count = '0;
   logic [31:0] kept_count = '0;
   int          errors = 0;
   int          cycles = 0;
   int          hold_off = 0;
   bit          stall_req = 1'b0;
   bit          stall_seen = 1'b0;
   bit          taken = 1'b0;
   bit          send_enable = 1'b1;
   int          burst_left = 0;
   int          gap_left = 0;

   initial forever #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic bit is_nan(logic [31:0] b);
      return (b & fwpq_pkg::MAG_MASK) > fwpq_pkg::EXP_ALL;
   endfunction

   function automatic logic [31:0] round_sixteenths(logic [31:0] w);
      logic [31:0] sgn;
      logic [7:0]  e;
      logic [63:0] sig;
      logic [31:0] r;
      int          k;
      int          p;
      sgn = w & fwpq_pkg::SIGN_MASK;
      e = w[30:23];
      if (e == 8'hFF) return w;
      if (e >= 251) return sgn | fwpq_pkg::EXP_ALL;
      if (e >= 146) return w;
      if (e < 122) return sgn;
      k = 146 - e;
      sig = {40'd0, 1'b1, w[22:0]};
      r = 32'((sig + (64'd1 << (k - 1))) >> k);
      if (r == 0) return sgn;
      p = 0;
      for (int i = 31; i >= 0; i--)
         if (r[i] && p == 0) p = i;
      return sgn | (32'(p + 123) << 23) | ((r << (23 - p)) & 32'h007F_FFFF);
   endfunction

   // update counters and queue the expected result, if one is emitted, for one accepted weight
   task automatic predict_filter(fwpq_pkg::req_type it);
      bit                keep;
      logic [31:0]       val;
      fwpq_pkg::rsp_type r;
      val = it.weight_bits;
      keep = 1'b1;
      if (cur_mode == fwpq_pkg::MODE_PRUNE)
         keep = !is_nan(it.weight_bits) && !is_nan(cur_threshold) &&
                (cur_threshold[31] ||
                 (it.weight_bits & fwpq_pkg::MAG_MASK) >= cur_threshold);
      else if (cur_mode == fwpq_pkg::MODE_QUANTIZE)
         val = round_sixteenths(it.weight_bits);
      if (seen_count != fwpq_pkg::SAT_MAX) seen_count = seen_count + 1;
      if (keep && kept_count != fwpq_pkg::SAT_MAX) kept_count = kept_count + 1;
      if (!keep && !it.last) return;
      r.value_bits = keep ? val : '0;
      r.value_valid = keep;
      r.end_of_stream = it.last;
      r.total_read = it.last ? seen_count : '0;
      r.total_written = it.last ? kept_count : '0;
      filtered_q = {filtered_q, r};
      if (it.last) begin
         seen_count = '0;
         kept_count = '0;
      end
   endtask

   // driver: bursts and gaps, new values set at the falling edge
   always @(negedge clock) begin
      if (!reset && push && !taken) begin
         // hold the offered item until it is taken
      end else if (!reset && send_enable && weight_q.size() > 0) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            push <= 1'b0;
         end else begin
            req_data <= weight_q[0];
            push <= 1'b1;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 30);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end else begin
         push <= 1'b0;
      end
   end

   // acceptance at the rising edge: predict and drop from the pending queue
   always @(posedge clock) begin
      taken <= !reset && push && !full;
      if (!reset && push && !full) begin
         predict_filter(weight_q.pop_front());
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (reset) pop <= 1'b0;
      else if (stall_req && !stall_seen) begin
         stall_seen <= 1'b1;
         hold_off <= 200;
         pop <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         pop <= 1'b0;
      end else
         pop <= (cycles % 64 < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
   end

   // monitor
   always @(posedge clock) begin
      fwpq_pkg::rsp_type want;
      if (!reset && pop && !empty) begin
         if (filtered_q.size() == 0) begin
            $error("transfer with nothing expected: %h", rsp_data);
            errors++;
         end else begin
            want = filtered_q.pop_front();
            if (rsp_data.value_bits !== want.value_bits) begin
               $error("value_bits exp %h got %h", want.value_bits, rsp_data.value_bits);
               errors++;
            end
            if (rsp_data.value_valid !== want.value_valid) begin
               $error("value_valid exp %b got %b", want.value_valid, rsp_data.value_valid);
               errors++;
            end
            if (rsp_data.end_of_stream !== want.end_of_stream) begin
               $error("end_of_stream exp %b got %b", want.end_of_stream,
                      rsp_data.end_of_stream);
               errors++;
            end
            if (rsp_data.total_read !== want.total_read) begin
               $error("total_read exp %0d got %0d", want.total_read, rsp_data.total_read);
               errors++;
            end
            if (rsp_data.total_written !== want.total_written) begin
               $error("total_written exp %0d got %0d", want.total_written,
                      rsp_data.total_written);
               errors++;
            end
         end
      end
   end

   task automatic write_csr(logic idx, logic [31:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == fwpq_pkg::CSR_MODE) cur_mode = data[1:0];
      else cur_threshold = data;
   endtask

   task automatic wait_drained();
      while (weight_q.size() > 0 || push || filtered_q.size() > 0) @(negedge clock);
      // pruned items give no result, let the pipeline empty
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [31:0] random_weight();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 7))
         0: w[30:23] = 8'($urandom_range(118, 150));
         1: w[30:23] = 8'($urandom_range(120, 135));
         2: w[30:23] = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
         3: w[30:23] = 8'($urandom_range(248, 254));
         default: ;
      endcase
      return w;
   endfunction

   task automatic queue_stream(int count);
      fwpq_pkg::req_type it;
      for (int i = 0; i < count; i++) begin
         it.weight_bits = random_weight();
         it.last = (i == count - 1) || ($urandom_range(0, 40) == 0);
         weight_q = {weight_q, it};
      end
   endtask

   localparam logic [31:0] SPECIALS[14] = '{
      32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
      32'hFFFF_FFFF, 32'h3D00_0000, 32'hBD00_0000, 32'h3D40_0000, 32'h7F7F_FFFF,
      32'h3F80_0000, 32'h3CFF_FFFF, 32'h4B00_0001, 32'h0000_0001};

   initial begin
      fwpq_pkg::req_type it;
      logic [31:0]       thresholds[5];
      thresholds = '{32'h0000_0000, 32'h3F00_0000, 32'h7FC0_0000, 32'hBF80_0000,
                     32'h7F80_0000};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset mode (pass), then each mode over the special values
      for (int m = 0; m < 4; m++) begin
         if (m > 0) write_csr(fwpq_pkg::CSR_MODE, 32'((m == 3) ? 2 : m - 1));
         if (m == 1) write_csr(fwpq_pkg::CSR_THRESHOLD, 32'h3D00_0000);
         if (m == 3) write_csr(fwpq_pkg::CSR_MODE, 32'd3);
         foreach (SPECIALS[i]) begin
            it.weight_bits = SPECIALS[i];
            it.last = (i == 13) || (i == 6);
            weight_q = {weight_q, it};
         end
         wait_drained();
      end

      // long receiver stall while the sender keeps going
      write_csr(fwpq_pkg::CSR_MODE, 32'(fwpq_pkg::MODE_PASS));
      stall_req = 1'b1;
      queue_stream(60);
      wait_drained();

      for (int ph = 0; ph < 10; ph++) begin
         write_csr(fwpq_pkg::CSR_MODE, 32'(ph % 3));
         write_csr(fwpq_pkg::CSR_THRESHOLD, (ph < 5) ? thresholds[ph] : random_weight());
         queue_stream(110);
         wait_drained();
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
